// ----- rtl/p6ru_pkg.sv -----
`timescale 1ns / 1ps

package p6ru_pkg;

  // default row length limit of the row store
  localparam int MAX_ROW_PIXELS_DEF = 320;

  // largest bin factor in either direction
  localparam int BIN_MAX = 16;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROW_WIDTH   = 2'd0,
    CFG_HORIZ_BIN   = 2'd1,
    CFG_VERT_BIN    = 2'd2,
    CFG_COLUMN_SKIP = 2'd3
  } cfg_index_t;

  // position of a byte inside its 3-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // horizontal group accumulator
  typedef struct packed {
    logic [7:0] gsum;
    logic [4:0] gfill;
    logic [8:0] osent;
  } grp_state_t;

  // outcome of one pixel in the accumulate stage
  typedef struct packed {
    grp_state_t st;
    logic [7:0] val;
    logic       emit;
    logic [7:0] sum;
    logic       done;
  } pix_result_t;

  // saturating 8-bit add
  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

// ----- rtl/packed_6bit_row_unpack_bin_core.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake               payload
// in        in   in_valid / in_stall     raw_byte[7:0]
// out       out  out_valid / out_stall   binned_pixel[7:0], row_done
// cfg       in   cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[8:0]
//
// one camera byte per cycle while input is not stalled; a result is registered into the
// accumulate stage, then the result queue, before it can leave. the row store is split
// into even and odd column banks so the two pixels of a third byte read and write in the
// same cycle; when a row ends on an even column the second pixel is held pending and goes
// through the store later; input stalls while it is pending and while the 8-entry result
// queue lacks room for two results from the accumulate stage and two from a new byte.
// reset is synchronous and clears all control state; the row store is not cleared.

module packed_6bit_row_unpack_bin_core #(
  parameter int MAX_ROW_PIXELS = p6ru_pkg::MAX_ROW_PIXELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] raw_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] binned_pixel,
  output logic       row_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int STORE_DEPTH = MAX_ROW_PIXELS + 4;
  localparam int COL_W       = $clog2(STORE_DEPTH);
  localparam int BANK_DEPTH  = (STORE_DEPTH + 1) / 2;
  localparam int BANK_AW     = COL_W - 1;
  localparam int W_LIMIT     = (MAX_ROW_PIXELS > 511) ? 511 : MAX_ROW_PIXELS;
  localparam logic [8:0] W_MAX = 9'(W_LIMIT);
  localparam logic [4:0] B_MAX = 5'(p6ru_pkg::BIN_MAX);

  typedef struct packed {
    logic [5:0]       pix;
    logic [COL_W-1:0] col;
    logic             first;
    logic             last;
    logic             inwin;
    logic             row_end;
  } lane_t;

  // configuration registers
  logic [8:0] row_width;
  logic [4:0] horiz_bin;
  logic [4:0] vert_bin;
  logic       column_skip;

  // effective configuration
  logic [8:0]  w_eff;
  logic [4:0]  hb_eff;
  logic [4:0]  vb_eff;
  logic [11:0] row_len;

  always_comb begin
    w_eff  = (row_width == 9'd0) ? 9'd1 : ((row_width > W_MAX) ? W_MAX : row_width);
    hb_eff = (horiz_bin == 5'd0) ? 5'd1 : ((horiz_bin > B_MAX) ? B_MAX : horiz_bin);
    vb_eff = (vert_bin == 5'd0) ? 5'd1 : ((vert_bin > B_MAX) ? B_MAX : vert_bin);
    row_len = ({3'b000, w_eff} + {11'd0, column_skip} + 12'd3) & ~12'd3;
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= 9'd320;
      horiz_bin   <= 5'd1;
      vert_bin    <= 5'd1;
      column_skip <= 1'b0;
    end else if (cfg_valid) begin
      case (p6ru_pkg::cfg_index_t'(cfg_index))
        p6ru_pkg::CFG_ROW_WIDTH:   row_width   <= cfg_data;
        p6ru_pkg::CFG_HORIZ_BIN:   horiz_bin   <= cfg_data[4:0];
        p6ru_pkg::CFG_VERT_BIN:    vert_bin    <= cfg_data[4:0];
        p6ru_pkg::CFG_COLUMN_SKIP: column_skip <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // row counter step within a vertical bin
  function automatic logic [3:0] bump_rows(input logic [3:0] r, input logic [4:0] vb);
    logic [4:0] r1;
    r1 = {1'b0, r} + 5'd1;
    return (r1 >= vb) ? 4'd0 : r1[3:0];
  endfunction

  // per-pixel flags at a given column and row of the bin
  function automatic lane_t make_lane(input logic [5:0] pix, input logic [COL_W-1:0] col,
                                      input logic [3:0] rows);
    lane_t      l;
    logic [11:0] c12;
    c12       = 12'(col);
    l.pix     = pix;
    l.col     = col;
    l.first   = (rows == 4'd0);
    l.last    = (({1'b0, rows} + 5'd1) >= vb_eff);
    l.inwin   = (c12 >= {11'd0, column_skip}) &&
                ((c12 - {11'd0, column_skip}) < {3'b000, w_eff});
    l.row_end = ((c12 + 12'd1) >= row_len);
    return l;
  endfunction

  // accumulate one pixel into the store value and the horizontal group
  function automatic p6ru_pkg::pix_result_t take_pixel(input p6ru_pkg::grp_state_t st,
                                                       input lane_t l,
                                                       input logic [7:0] mem);
    p6ru_pkg::pix_result_t r;
    logic [7:0]  s;
    logic [4:0]  fill;
    logic [9:0]  k;
    logic [14:0] prod;
    r.st   = st;
    r.val  = l.first ? {2'b00, l.pix} : p6ru_pkg::sat_add8(mem, {2'b00, l.pix});
    r.emit = 1'b0;
    r.sum  = 8'd0;
    r.done = 1'b0;
    s      = p6ru_pkg::sat_add8(st.gsum, r.val);
    fill   = st.gfill + 5'd1;
    k      = {1'b0, st.osent} + 10'd1;
    prod   = 15'(k) * 15'(hb_eff);
    if (l.last && l.inwin) begin
      if (fill >= hb_eff) begin
        r.emit     = 1'b1;
        r.sum      = s;
        r.done     = (prod <= 15'(w_eff)) && ((prod + 15'(hb_eff)) > 15'(w_eff));
        r.st.osent = st.osent + 9'd1;
        r.st.gsum  = 8'd0;
        r.st.gfill = 5'd0;
      end else begin
        r.st.gsum  = s;
        r.st.gfill = fill;
      end
    end
    if (l.row_end) begin
      r.st.gsum  = 8'd0;
      r.st.gfill = 5'd0;
      r.st.osent = 9'd0;
    end
    return r;
  endfunction

  // unpack state
  p6ru_pkg::phase_t byte_phase, byte_phase_next;
  logic [5:0]       partial_pixel, partial_pixel_next;
  logic [COL_W-1:0] pixel_column, pixel_column_next;
  logic [3:0]       rows_in_bin, rows_in_bin_next;
  logic             pend_valid, pend_valid_next;
  logic [5:0]       pend_pix;

  // accumulate stage
  lane_t                 s1_lane0, s1_lane1;
  logic                  s1_valid0, s1_valid1;
  p6ru_pkg::grp_state_t  grp, grp_next;
  logic [7:0]            q_even, q_odd;

  // row store banks
  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];

  // result queue
  logic [8:0]                      fifo_mem [p6ru_pkg::FIFO_DEPTH];
  logic [p6ru_pkg::FIFO_AW-1:0]    wp, rp;
  logic [p6ru_pkg::FIFO_CW-1:0]    count;
  logic                            room;
  logic                            pop;

  // issue stage signals
  logic [7:0]       d;
  logic [5:0]       byte_pix_a;
  logic [5:0]       pix_a;
  lane_t            lane_a, lane_b;
  logic [COL_W-1:0] col_b, col_c;
  logic [3:0]       rib_b, rib_c;
  logic             conflict;
  logic             accept;
  logic             issue_pend;
  logic             issue_a;
  logic             two;
  logic [BANK_AW-1:0] rd_addr_even, rd_addr_odd;

  // queue space for everything that may still arrive
  always_comb begin
    logic [p6ru_pkg::FIFO_CW:0] need;
    need = {1'b0, count} + ((s1_valid0 || s1_valid1) ? (p6ru_pkg::FIFO_CW + 1)'(2) : '0)
           + (p6ru_pkg::FIFO_CW + 1)'(2);
    room = (need <= (p6ru_pkg::FIFO_CW + 1)'(p6ru_pkg::FIFO_DEPTH));
  end

  assign in_stall   = pend_valid || !room;
  assign accept     = in_valid && !in_stall;
  assign issue_pend = pend_valid && room;
  assign issue_a    = accept || issue_pend;

  // unpack the byte
  always_comb begin
    d = ~raw_byte;
    case (byte_phase)
      p6ru_pkg::PH_FIRST:  byte_pix_a = d[7:2];
      p6ru_pkg::PH_SECOND: byte_pix_a = partial_pixel | {2'b00, d[7:4]};
      p6ru_pkg::PH_THIRD:  byte_pix_a = partial_pixel | {4'b0000, d[7:6]};
      default:             byte_pix_a = d[7:2];
    endcase
    pix_a = pend_valid ? pend_pix : byte_pix_a;
  end

  // columns and flags of the one or two pixels issued this cycle
  always_comb begin
    lane_a   = make_lane(pix_a, pixel_column, rows_in_bin);
    col_b    = lane_a.row_end ? '0 : (pixel_column + 1'b1);
    rib_b    = lane_a.row_end ? bump_rows(rows_in_bin, vb_eff) : rows_in_bin;
    lane_b   = make_lane(d[5:0], col_b, rib_b);
    col_c    = lane_b.row_end ? '0 : (col_b + 1'b1);
    rib_c    = lane_b.row_end ? bump_rows(rib_b, vb_eff) : rib_b;
    conflict = (col_b[0] == pixel_column[0]);
    two      = accept && (byte_phase == p6ru_pkg::PH_THIRD) && !conflict;
  end

  // next unpack state
  always_comb begin
    byte_phase_next    = byte_phase;
    partial_pixel_next = partial_pixel;
    pixel_column_next  = pixel_column;
    rows_in_bin_next   = rows_in_bin;
    pend_valid_next    = pend_valid && !issue_pend;
    if (issue_a) begin
      pixel_column_next = two ? col_c : col_b;
      rows_in_bin_next  = two ? rib_c : rib_b;
    end
    if (accept) begin
      case (byte_phase)
        p6ru_pkg::PH_FIRST: begin
          partial_pixel_next = {d[1:0], 4'b0000};
          byte_phase_next    = p6ru_pkg::PH_SECOND;
        end
        p6ru_pkg::PH_SECOND: begin
          partial_pixel_next = {d[3:0], 2'b00};
          byte_phase_next    = p6ru_pkg::PH_THIRD;
        end
        p6ru_pkg::PH_THIRD: begin
          partial_pixel_next = 6'd0;
          byte_phase_next    = p6ru_pkg::PH_FIRST;
          pend_valid_next    = conflict;
        end
        default: begin
          byte_phase_next = p6ru_pkg::PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= p6ru_pkg::PH_FIRST;
      partial_pixel <= 6'd0;
      pixel_column  <= '0;
      rows_in_bin   <= 4'd0;
      pend_valid    <= 1'b0;
      s1_valid0     <= 1'b0;
      s1_valid1     <= 1'b0;
    end else begin
      byte_phase    <= byte_phase_next;
      partial_pixel <= partial_pixel_next;
      pixel_column  <= pixel_column_next;
      rows_in_bin   <= rows_in_bin_next;
      pend_valid    <= pend_valid_next;
      s1_valid0     <= issue_a;
      s1_valid1     <= two;
    end
  end

  // pixel payload into the accumulate stage
  always_ff @(posedge clk) begin
    s1_lane0 <= lane_a;
    s1_lane1 <= lane_b;
    if (accept && byte_phase == p6ru_pkg::PH_THIRD && conflict) begin
      pend_pix <= d[5:0];
    end
  end

  // bank read addresses by column parity
  always_comb begin
    rd_addr_even = lane_a.col[0] ? lane_b.col[COL_W-1:1] : lane_a.col[COL_W-1:1];
    rd_addr_odd  = lane_a.col[0] ? lane_a.col[COL_W-1:1] : lane_b.col[COL_W-1:1];
  end

  // accumulate stage
  p6ru_pkg::pix_result_t res0, res1;
  logic [7:0] mem0, mem1;

  always_comb begin
    mem0 = s1_lane0.col[0] ? q_odd : q_even;
    mem1 = s1_lane1.col[0] ? q_odd : q_even;
    res0 = take_pixel(grp, s1_lane0, mem0);
    res1 = take_pixel(s1_valid0 ? res0.st : grp, s1_lane1, mem1);
    grp_next = grp;
    if (s1_valid0) begin
      grp_next = res0.st;
    end
    if (s1_valid1) begin
      grp_next = res1.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
    end else begin
      grp <= grp_next;
    end
  end

  // one write port per bank, the two lanes always fall in different banks
  logic               we_even, we_odd;
  logic [BANK_AW-1:0] wa_even, wa_odd;
  logic [7:0]         wd_even, wd_odd;

  always_comb begin
    we_even = (s1_valid0 && !s1_lane0.col[0]) || (s1_valid1 && !s1_lane1.col[0]);
    we_odd  = (s1_valid0 && s1_lane0.col[0]) || (s1_valid1 && s1_lane1.col[0]);
    wa_even = s1_lane0.col[0] ? s1_lane1.col[COL_W-1:1] : s1_lane0.col[COL_W-1:1];
    wd_even = s1_lane0.col[0] ? res1.val : res0.val;
    wa_odd  = s1_lane0.col[0] ? s1_lane0.col[COL_W-1:1] : s1_lane1.col[COL_W-1:1];
    wd_odd  = s1_lane0.col[0] ? res0.val : res1.val;
  end

  // row store read and write back
  always_ff @(posedge clk) begin
    q_even <= bank_even[rd_addr_even];
    q_odd  <= bank_odd[rd_addr_odd];
    if (we_even) begin
      bank_even[wa_even] <= wd_even;
    end
    if (we_odd) begin
      bank_odd[wa_odd] <= wd_odd;
    end
  end

  // result queue
  logic e0, e1;
  logic [1:0] n_push;
  logic [8:0] push_first;

  always_comb begin
    e0         = s1_valid0 && res0.emit;
    e1         = s1_valid1 && res1.emit;
    n_push     = {1'b0, e0} + {1'b0, e1};
    push_first = e0 ? {res0.done, res0.sum} : {res1.done, res1.sum};
  end

  assign out_valid    = (count != '0);
  assign pop          = out_valid && !out_stall;
  assign binned_pixel = fifo_mem[rp][7:0];
  assign row_done     = fifo_mem[rp][8];

  always_ff @(posedge clk) begin
    if (e0 || e1) begin
      fifo_mem[wp] <= push_first;
    end
    if (e0 && e1) begin
      fifo_mem[wp + 1'b1] <= {res1.done, res1.sum};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + p6ru_pkg::FIFO_AW'(n_push);
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + p6ru_pkg::FIFO_CW'(n_push) - p6ru_pkg::FIFO_CW'(pop);
    end
  end

endmodule

// ----- bench/p6ru_result_checker.sv -----
`timescale 1ns / 1ps

module p6ru_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] raw_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] binned_pixel,
  input  logic       row_done,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int STORE_DEPTH = p6ru_pkg::MAX_ROW_PIXELS_DEF + 4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } binned_result_t;

  // register copies
  logic [8:0] width_reg;
  logic [4:0] hbin_reg;
  logic [4:0] vbin_reg;
  logic       skip_reg;

  // unpack and binning state
  logic [7:0]       accum_row [STORE_DEPTH];
  p6ru_pkg::phase_t byte_slot;
  logic [5:0]       carry_bits;
  int               column;
  int               bin_row;
  logic [7:0]       group_total;
  int               group_count;
  logic [8:0]       pixels_sent;

  binned_result_t expected_pixels[$];
  int mismatches = 0;

  function automatic logic [7:0] capped_sum(input logic [7:0] a, input logic [7:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic int limit_to(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one 6-bit pixel through the row store and the horizontal group
  task automatic bin_pixel(input logic [5:0] pix);
    int w;
    int hb;
    int vb;
    int skip;
    int len;
    int c;
    logic [7:0] v;
    binned_result_t res;
    w    = limit_to(int'(width_reg), 1, p6ru_pkg::MAX_ROW_PIXELS_DEF);
    hb   = limit_to(int'(hbin_reg), 1, p6ru_pkg::BIN_MAX);
    vb   = limit_to(int'(vbin_reg), 1, p6ru_pkg::BIN_MAX);
    skip = int'(skip_reg);
    len  = ((w + skip + 3) / 4) * 4;
    c    = column;

    if (c < STORE_DEPTH) begin
      v = (bin_row == 0) ? {2'b00, pix} : capped_sum(accum_row[c], {2'b00, pix});
      accum_row[c] = v;
    end else begin
      v = {2'b00, pix};
    end

    // last row of the bin feeds the horizontal group
    if (bin_row + 1 >= vb && c >= skip && c - skip < w) begin
      group_total = capped_sum(group_total, v);
      group_count++;
      if (group_count >= hb) begin
        res.pixel = group_total;
        res.last  = (int'(pixels_sent) + 1 == w / hb);
        expected_pixels.push_back(res);
        pixels_sent = pixels_sent + 9'd1;
        group_total = '0;
        group_count = 0;
      end
    end

    // end of camera row
    if (c + 1 >= len) begin
      column      = 0;
      bin_row     = (bin_row + 1 >= vb) ? 0 : bin_row + 1;
      group_total = '0;
      group_count = 0;
      pixels_sent = '0;
    end else begin
      column = c + 1;
    end
  endtask

  // inverted byte into the 3-byte / 4-pixel unpacker
  task automatic unpack_byte(input logic [7:0] raw);
    logic [7:0] d;
    d = ~raw;
    case (byte_slot)
      p6ru_pkg::PH_FIRST: begin
        bin_pixel(d[7:2]);
        carry_bits = {d[1:0], 4'b0000};
        byte_slot  = p6ru_pkg::PH_SECOND;
      end
      p6ru_pkg::PH_SECOND: begin
        bin_pixel({carry_bits[5:4], d[7:4]});
        carry_bits = {d[3:0], 2'b00};
        byte_slot  = p6ru_pkg::PH_THIRD;
      end
      default: begin
        bin_pixel({carry_bits[5:2], d[7:6]});
        bin_pixel(d[5:0]);
        carry_bits = '0;
        byte_slot  = p6ru_pkg::PH_FIRST;
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    binned_result_t want;
    if (rst) begin
      width_reg   = 9'(p6ru_pkg::MAX_ROW_PIXELS_DEF);
      hbin_reg    = 5'd1;
      vbin_reg    = 5'd1;
      skip_reg    = 1'b0;
      byte_slot   = p6ru_pkg::PH_FIRST;
      carry_bits  = '0;
      column      = 0;
      bin_row     = 0;
      group_total = '0;
      group_count = 0;
      pixels_sent = '0;
      expected_pixels.delete();
    end else begin
      // result compare against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: binned_pixel %0d row_done %0d", binned_pixel, row_done);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (binned_pixel !== want.pixel) begin
            $error("binned_pixel: expected %0d, actual %0d", want.pixel, binned_pixel);
            mismatches++;
          end
          if (row_done !== want.last) begin
            $error("row_done: expected %0d, actual %0d", want.last, row_done);
            mismatches++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          p6ru_pkg::CFG_ROW_WIDTH:   width_reg = cfg_data;
          p6ru_pkg::CFG_HORIZ_BIN:   hbin_reg  = cfg_data[4:0];
          p6ru_pkg::CFG_VERT_BIN:    vbin_reg  = cfg_data[4:0];
          p6ru_pkg::CFG_COLUMN_SKIP: skip_reg  = cfg_data[0];
          default: ;
        endcase
      end

      // accepted camera byte
      if (in_valid && !in_stall) unpack_byte(raw_byte);
    end
    fail_count <= mismatches;
    pending    <= expected_pixels.size();
  end

endmodule

// ----- bench/tb_packed_6bit_row_unpack_bin_core.sv -----
`timescale 1ns / 1ps

module tb_packed_6bit_row_unpack_bin_core;

  localparam int ITEM_TARGET = 1000;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] raw_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] binned_pixel;
  logic       row_done;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  // register values last written
  int cur_width = p6ru_pkg::MAX_ROW_PIXELS_DEF;
  int cur_vbin = 1;
  int cur_skip = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  packed_6bit_row_unpack_bin_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_byte     (raw_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .binned_pixel (binned_pixel),
    .row_done     (row_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  p6ru_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_byte     (raw_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .binned_pixel (binned_pixel),
    .row_done     (row_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each request
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic logic [7:0] draw_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // bytes in one camera row at the current settings
  function automatic int row_bytes();
    int w;
    w = (cur_width < 1) ? 1 :
        ((cur_width > p6ru_pkg::MAX_ROW_PIXELS_DEF) ? p6ru_pkg::MAX_ROW_PIXELS_DEF : cur_width);
    return (((w + cur_skip + 3) / 4) * 4) * 3 / 4;
  endfunction

  function automatic int rows_per_bin();
    return (cur_vbin < 1) ? 1 : ((cur_vbin > p6ru_pkg::BIN_MAX) ? p6ru_pkg::BIN_MAX : cur_vbin);
  endfunction

  task automatic write_reg(input p6ru_pkg::cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = 9'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int width, input int hb, input int vb, input int skip);
    write_reg(p6ru_pkg::CFG_ROW_WIDTH, width);
    write_reg(p6ru_pkg::CFG_HORIZ_BIN, hb);
    write_reg(p6ru_pkg::CFG_VERT_BIN, vb);
    write_reg(p6ru_pkg::CFG_COLUMN_SKIP, skip);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_width = width & 9'h1FF;
    cur_vbin  = vb & 5'h1F;
    cur_skip  = skip & 1;
  endtask

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    raw_byte = value;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // whole camera rows; a negative fill draws each byte at random
  task automatic send_rows(input int rows, input int fill);
    repeat (rows * row_bytes()) send_byte((fill < 0) ? draw_byte() : 8'(fill));
  endtask

  // sender holds off until every expected result is out
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] mix [6];
    int width;
    int hb;
    int vb;
    int skip;
    mix = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0};

    rst       = 1'b1;
    in_valid  = 1'b0;
    raw_byte  = '0;
    cfg_valid = 1'b0;
    cfg_index = p6ru_pkg::CFG_ROW_WIDTH;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // longest row first so every store entry is written before any add
    set_config(p6ru_pkg::MAX_ROW_PIXELS_DEF, 1, 1, 1);
    send_rows(1, -1);
    settle();

    // two-row bin of pairs with bit patterns
    set_config(4, 2, 2, 0);
    foreach (mix[i]) send_byte(mix[i]);
    settle();

    // horizontal saturation, zero vertical bin, trailing partial group dropped
    set_config(6, 5, 0, 1);
    send_rows(1, 8'h00);
    settle();

    // width below the horizontal bin: no output
    set_config(1, 31, 0, 1);
    send_rows(1, 8'hFF);
    settle();

    // zero width and bin, vertical saturation over five rows
    set_config(0, 0, 5, 0);
    send_rows(5, 8'h00);
    settle();

    // random phases, mostly whole bins
    while (bytes_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: width = $urandom_range(1, 40);
        6, 7, 8:          width = $urandom_range(41, p6ru_pkg::MAX_ROW_PIXELS_DEF);
        default: begin
          case ($urandom_range(0, 2))
            0:       width = 0;
            1:       width = p6ru_pkg::MAX_ROW_PIXELS_DEF;
            default: width = $urandom_range(p6ru_pkg::MAX_ROW_PIXELS_DEF + 1, 511);
          endcase
        end
      endcase
      hb   = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 31);
      vb   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31);
      skip = $urandom_range(0, 1);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);

      set_config(width, hb, vb, skip);
      // keep the bytes of one vertical bin of rows to at most 600
      if (row_bytes() * rows_per_bin() > 600) set_config(width, hb, 1, skip);

      if ($urandom_range(0, 6) != 0) begin
        send_rows(rows_per_bin() * $urandom_range(1, 2), -1);
      end else begin
        // broken sequence: leaves the row part done for the next settings
        repeat ($urandom_range(1, 2 * row_bytes())) send_byte(draw_byte());
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
